// File: rtl/core/clustered_transposition_table_macros.svh
// assertion helpers for the transposition table
`ifndef CLUSTERED_TRANSPOSITION_TABLE_MACROS_SVH
`define CLUSTERED_TRANSPOSITION_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ctt_pkg.sv
package ctt_pkg;

  // request kinds
  localparam logic [1:0] REQ_PROBE = 2'd0;
  localparam logic [1:0] REQ_MOVE  = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;

  // bound flags
  localparam logic [1:0] BOUND_EMPTY = 2'd0;
  localparam logic [1:0] BOUND_ALPHA = 2'd1;
  localparam logic [1:0] BOUND_BETA  = 2'd2;
  localparam logic [1:0] BOUND_EXACT = 2'd3;

  localparam logic [6:0] MATE_RESET = 7'd100;

  // one slot; no checksum is kept
  typedef struct packed {
    logic [63:0]       key;
    logic [1:0]        flag;
    logic [7:0]        move;
    logic signed [7:0] value;
    logic [7:0]        depth;
  } ent_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

endpackage

// File: rtl/core/clustered_transposition_table.sv
// channel  | dir | handshake                 | contents
// s_axis   | in  | s_axis_tvalid/tready      | request beat, kind in tuser
// m_axis   | out | m_axis_tvalid/tready      | one result beat per request
// cfg      | in  | cfg_valid/cfg_ready       | mate_score write
//
// A request runs through accept, one slot-memory read per way, the compare
// of each way in the cycle after its read, then evaluation and write-back,
// and then the next beat is taken.
// After reset all 2**LOG2_ENTRIES + CLUSTER_WAYS slots of the slot memory
// are zeroed, one entry a cycle, with s_axis_tready low.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its evaluation holds until that register is free.
`include "clustered_transposition_table_macros.svh"

module clustered_transposition_table #(
  parameter int unsigned LOG2_ENTRIES = 12,
  parameter int unsigned CLUSTER_WAYS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // key[63:0], search_depth[71:64], ply[79:72], horizon[87:80], alpha[95:88],
  // beta[103:96], store_value[111:104], store_move[119:112],
  // bound_flag[121:120], zero fill
  input  logic [127:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // hit[0], result_value[8:1], found[9], best_move[17:10], collision[18],
  // zero fill
  output logic [23:0]  m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [6:0]   cfg_data_i
);

  localparam int unsigned NumSlots = 2**LOG2_ENTRIES + CLUSTER_WAYS;
  localparam int unsigned IdxW     = $clog2(NumSlots);
  localparam int unsigned WayW     = $clog2(CLUSTER_WAYS + 1);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(NumSlots - 1);

  ctt_pkg::state_e state_q, state_d;

  // request payload
  logic [1:0]        req_q;
  logic [63:0]       key_q;
  logic [7:0]        depth_q, ply_q, hor_q, smove_q;
  logic signed [7:0] alpha_q, beta_q, sval_q;
  logic [1:0]        sflag_q;

  // scan control
  logic [WayW-1:0] cnt_q;
  logic            rd_vld_q, rd_last_q;
  logic [IdxW-1:0] rd_addr_q, clr_q;
  logic            rd_en, mem_we, out_load, in_acc;
  logic [IdxW-1:0] rd_addr, wr_addr;
  ctt_pkg::ent_t   wr_ent, rd_ent_q;

  // scan results
  logic            match_q, sel_q, coll_q;
  ctt_pkg::ent_t   ment_q;
  logic [IdxW-1:0] sel_addr_q;

  logic [6:0]  mate_q;
  logic        m_valid_q;
  logic [23:0] m_data_q;

  ctt_pkg::ent_t mem_q [NumSlots];

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign rd_addr = {{(IdxW-LOG2_ENTRIES){1'b0}}, key_q[LOG2_ENTRIES-1:0]} + IdxW'(cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctt_pkg::ST_CLEAR: if (clr_q == LastSlot) state_d = ctt_pkg::ST_IDLE;
      ctt_pkg::ST_IDLE:  if (s_axis_tvalid_i) state_d = ctt_pkg::ST_SCAN;
      ctt_pkg::ST_SCAN:  if (rd_vld_q && rd_last_q) state_d = ctt_pkg::ST_FIN;
      ctt_pkg::ST_FIN:   if (!m_valid_q || m_axis_tready_i) state_d = ctt_pkg::ST_IDLE;
      default:           state_d = ctt_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    mem_we          = 1'b0;
    out_load        = 1'b0;
    wr_addr         = clr_q;
    wr_ent          = '0;
    unique case (state_q)
      ctt_pkg::ST_CLEAR: mem_we = 1'b1;
      ctt_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      ctt_pkg::ST_SCAN:  rd_en = (cnt_q < WayW'(CLUSTER_WAYS));
      ctt_pkg::ST_FIN: begin
        out_load     = !m_valid_q || m_axis_tready_i;
        mem_we       = out_load && (req_q == ctt_pkg::REQ_STORE);
        wr_addr      = sel_addr_q;
        wr_ent.key   = key_q;
        wr_ent.flag  = sflag_q;
        wr_ent.move  = smove_q;
        wr_ent.value = sval_q;
        wr_ent.depth = depth_q;
      end
      default: ;
    endcase
  end

  // state and clear counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctt_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ctt_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_ent;
    if (rd_en) rd_ent_q <= mem_q[rd_addr];
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q   <= s_axis_tuser_i;
      key_q   <= s_axis_tdata_i[63:0];
      depth_q <= s_axis_tdata_i[71:64];
      ply_q   <= s_axis_tdata_i[79:72];
      hor_q   <= s_axis_tdata_i[87:80];
      alpha_q <= s_axis_tdata_i[95:88];
      beta_q  <= s_axis_tdata_i[103:96];
      sval_q  <= s_axis_tdata_i[111:104];
      smove_q <= s_axis_tdata_i[119:112];
      sflag_q <= s_axis_tdata_i[121:120];
    end
  end

  // way sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      if (in_acc) cnt_q <= '0;
      else if (rd_en) cnt_q <= cnt_q + 1'b1;
      if (rd_en) begin
        rd_last_q <= (cnt_q == WayW'(CLUSTER_WAYS - 1));
        rd_addr_q <= rd_addr;
      end
    end
  end

  // compare each returned slot: first match, store target, collision
  logic rd_match, rd_cand;
  assign rd_match = (rd_ent_q.key == key_q) && (key_q != '0);
  assign rd_cand  = (rd_ent_q.key == '0) || (rd_ent_q.key == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      sel_q   <= 1'b0;
      coll_q  <= 1'b0;
    end else if (in_acc) begin
      match_q <= 1'b0;
      sel_q   <= 1'b0;
      coll_q  <= 1'b0;
    end else if (rd_vld_q) begin
      if (rd_match && !match_q) match_q <= 1'b1;
      if (!sel_q && (rd_cand || rd_last_q)) begin
        sel_q  <= 1'b1;
        coll_q <= !rd_cand;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && rd_match && !match_q) ment_q <= rd_ent_q;
    if (rd_vld_q && !sel_q && (rd_cand || rd_last_q)) sel_addr_q <= rd_addr_q;
  end

  // result evaluation
  logic [7:0]        mag;
  logic [9:0]        reach;
  logic [8:0]        lim;
  logic              deep_ok, demote;
  logic signed [7:0] ev, res_val;
  logic              res_hit, res_found, res_coll;
  logic [7:0]        res_move;

  always_comb begin
    mag     = ment_q.value[7] ? 8'(-ment_q.value) : 8'(ment_q.value);
    reach   = 10'(ply_q) + 10'(depth_q) + 10'(hor_q);
    lim     = {2'b00, mate_q} - {1'b0, mag};
    deep_ok = ment_q.depth >= depth_q;
    demote  = (depth_q < ment_q.depth) && !lim[8] && ({2'b00, lim[7:0]} > reach);
    ev      = ment_q.value;
    if (mag > 8'd1 && demote) ev = ment_q.value[7] ? -8'sd1 : 8'sd1;

    res_hit   = 1'b0;
    res_val   = '0;
    res_found = 1'b0;
    res_move  = '0;
    res_coll  = 1'b0;
    unique case (req_q)
      ctt_pkg::REQ_PROBE: begin
        res_found = match_q;
        if (match_q) begin
          unique case (ment_q.flag)
            ctt_pkg::BOUND_EXACT: begin
              res_hit = (mag > 8'd1) || deep_ok;
              priority if (ev < alpha_q) res_val = alpha_q;
              else if (beta_q < ev)      res_val = beta_q;
              else                       res_val = ev;
            end
            ctt_pkg::BOUND_ALPHA: begin
              res_hit = deep_ok && (ment_q.value <= alpha_q);
              res_val = alpha_q;
            end
            ctt_pkg::BOUND_BETA: begin
              res_hit = deep_ok && (ment_q.value >= beta_q);
              res_val = beta_q;
            end
            default: ;
          endcase
        end
      end
      ctt_pkg::REQ_MOVE: begin
        res_found = match_q;
        res_move  = match_q ? ment_q.move : 8'd0;
      end
      ctt_pkg::REQ_STORE: res_coll = coll_q;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {5'd0, res_coll, res_move, res_found, res_val, res_hit};
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_q <= ctt_pkg::MATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mate_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `CTT_ASSERT_NOW(a_no_accept_in_clear, state_q == ctt_pkg::ST_CLEAR, !s_axis_tready_o, "request taken during clear")
  `CTT_ASSERT_NOW(a_write_source, mem_we && state_q != ctt_pkg::ST_CLEAR, req_q == ctt_pkg::REQ_STORE && sel_q, "slot write without a chosen store target")
  `CTT_ASSERT_NOW(a_load_when_free, out_load, !m_valid_q || m_axis_tready_i, "result overwrites a waiting beat")
  `CTT_ASSERT_NEXT(a_accept_starts_scan, in_acc, state_q == ctt_pkg::ST_SCAN && cnt_q == '0, "scan did not start after accept")
  `CTT_ASSERT_NOW(a_coll_store_only, out_load && req_q != ctt_pkg::REQ_STORE, !res_coll, "collision reported on a probe")

endmodule
